### rtl/core/hcri_pkg.sv
// package for the chained hash table with replacement
// constants and result struct, no dependencies
package hcri_pkg;

    localparam logic [2:0] ST_HOME  = 3'd0;
    localparam logic [2:0] ST_SYN   = 3'd1;
    localparam logic [2:0] ST_MOVED = 3'd2;
    localparam logic [2:0] ST_FULL  = 3'd3;
    localparam logic [2:0] ST_READ  = 3'd4;

    localparam logic ACT_INSERT = 1'b0;
    localparam logic ACT_READ   = 1'b1;

    localparam int TBL_DEPTH = 64;
    localparam int AW     = $clog2(TBL_DEPTH);
    localparam int CW     = $clog2(TBL_DEPTH + 1);
    localparam int KEY_W  = 31;
    localparam int SLOT_W = AW;
    localparam int LINK_W = 7;

    // end of chain marker
    localparam logic [LINK_W-1:0] LINK_NONE = '1;

    typedef struct packed {
        logic [LINK_W-1:0] read_next;
        logic              read_used;
        logic [KEY_W-1:0]  read_key;
        logic [SLOT_W-1:0] moved_slot;
        logic [SLOT_W-1:0] placed_slot;
        logic [2:0]        status;
    } result_t;

    // result word of an insert that found no room
    localparam result_t RES_FULL = '{read_next: LINK_NONE, read_used: 1'b0,
        read_key: '0, moved_slot: '0, placed_slot: '0, status: ST_FULL};

endpackage

### rtl/core/hash_chain_replace_insert_top.sv
// chained hash table with replacement, top level
// depends on hcri_pkg, hcri_modulo
//
// usage: s_axis carries one request word, m_axis one result word per request.
// cfg writes table_size and clears the table; it is taken only while idle.
// a read answers through S_RD, which takes the entry read into the result,
// then the output register; an insert into a full table answers the cycle
// after its request is accepted. an insert runs the shared 31-step modulo
// unit for the key's home slot; on a collision the unit runs again for the
// resident's home, then the predecessor walk (up to 64, only if the resident
// is displaced), the chain tail walk (up to 65) and the free slot probe (up
// to 63) take one table entry per cycle, and then the write states follow.
// the sequencer takes one request at a time; s_axis_tready is low while busy
// and while a result word waits; the next request is taken the cycle after
// the result word leaves.
// after reset, a clearing pass over all 64 entries runs before the first
// request is taken; a cfg write starts the same pass.
// if m_axis_tready is low the result word is held until taken.
module hash_chain_replace_insert_top
    (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [6:0]  cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [30:0] key, [36:31] slot, zero fill to 40
    input  logic [39:0] s_axis_tdata,
    // [0] action
    input  logic        s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [2:0] status, [8:3] placed_slot, [14:9] moved_slot, [45:15] read_key,
    // [46] read_used, [53:47] read_next, zero fill to 56
    output logic [55:0] m_axis_tdata
    );
    import hcri_pkg::*;

    localparam logic [3:0] S_CLEAR = 4'd0, S_IDLE = 4'd1, S_MOD = 4'd2,
        S_CHK = 4'd3, S_RMOD = 4'd4, S_PRED = 4'd5, S_TAIL = 4'd6,
        S_FREE = 4'd7, S_W1 = 4'd8, S_W2 = 4'd9, S_W3 = 4'd10,
        S_W4 = 4'd11, S_RD = 4'd12;

    // table store: key, used flag and link memories on one read address
    logic [KEY_W-1:0]  key_mem [TBL_DEPTH];
    logic              used_mem [TBL_DEPTH];
    logic [LINK_W-1:0] link_mem [TBL_DEPTH];
    logic [KEY_W-1:0]  rd_key;
    logic              rd_used;
    logic [LINK_W-1:0] rd_link;
    logic [AW-1:0]     raddr;
    logic              kwe, lwe;
    logic [AW-1:0]     kaddr, laddr;
    logic [KEY_W-1:0]  kdata;
    logic              udata;
    logic [LINK_W-1:0] ldata;

    logic [3:0]        state_reg, state_next;
    logic [6:0]        size_reg;
    logic [CW-1:0]     n;
    logic [CW-1:0]     cnt_reg;
    logic [AW-1:0]     cur_reg, home_reg, tail_reg, pred_reg, free_reg;
    logic              pred_ok_reg, disp_reg;
    logic [KEY_W-1:0]  key_reg, res_key_reg;
    logic [LINK_W-1:0] ilink_reg;
    logic [CW-1:0]     used_cnt_reg;
    result_t           res_reg;
    logic              outv_reg;
    logic              finish;
    logic              mstart, mdone;
    logic [AW-1:0]     mrem;
    logic [KEY_W-1:0]  mdiv;
    logic [AW-1:0]     cur_inc;
    logic              link_good, is_pred, pred_stop, tail_stop;

    always_ff @(posedge clk)
    begin
        if (kwe)
        begin
            key_mem[kaddr]  <= kdata;
            used_mem[kaddr] <= udata;
        end
        if (lwe) link_mem[laddr] <= ldata;
        rd_key  <= key_mem[raddr];
        rd_used <= used_mem[raddr];
        rd_link <= link_mem[raddr];
    end

    // effective size clamp
    always_comb
    begin
        if (size_reg == 7'd0)
            n = CW'(1);
        else if (size_reg > CW'(TBL_DEPTH))
            n = CW'(TBL_DEPTH);
        else
            n = size_reg;
    end

    hcri_modulo u_mod
        (
        .clk(clk), .rst_n(rst_n), .start(mstart), .dividend(mdiv),
        .divisor(n), .done(mdone), .remainder(mrem)
        );

    // walk decisions on the entry just read
    assign link_good = !rd_link[LINK_W-1] && (rd_link < n);
    assign is_pred   = (rd_link == {1'b0, home_reg});
    assign pred_stop = is_pred || !link_good || (cnt_reg == CW'(TBL_DEPTH - 1));
    assign tail_stop = !link_good || (cnt_reg == CW'(TBL_DEPTH));
    assign cur_inc   = ({1'b0, cur_reg} + CW'(1) >= n) ? '0 : cur_reg + AW'(1);

    assign cfg_ready     = (state_reg == S_IDLE) && !outv_reg;
    assign s_axis_tready = (state_reg == S_IDLE) && !outv_reg && !cfg_valid;
    assign m_axis_tvalid = outv_reg;
    assign m_axis_tdata  = {2'b00, res_reg};

    // sequencer control, memory ports and modulo start
    always_comb
    begin
        raddr = cur_reg;
        kwe = 1'b0; lwe = 1'b0;
        kaddr = cur_reg; laddr = cur_reg;
        kdata = key_reg; udata = 1'b1; ldata = LINK_NONE;
        mstart = 1'b0;
        mdiv = key_reg;
        finish = 1'b0;
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                kwe = 1'b1; lwe = 1'b1; kdata = '0; udata = 1'b0;
                if (cur_reg == AW'(TBL_DEPTH - 1))
                    state_next = S_IDLE;
            end
            S_IDLE:
                if (cfg_valid && cfg_ready)
                    state_next = S_CLEAR;
                else if (s_axis_tvalid && s_axis_tready)
                begin
                    if (s_axis_tuser == ACT_READ)
                    begin
                        raddr = s_axis_tdata[KEY_W+SLOT_W-1:KEY_W];
                        state_next = S_RD;
                    end
                    else if (used_cnt_reg >= n)
                        finish = 1'b1;
                    else
                    begin
                        mstart = 1'b1;
                        mdiv = s_axis_tdata[KEY_W-1:0];
                        state_next = S_MOD;
                    end
                end
            S_RD:
            begin
                finish = 1'b1;
                state_next = S_IDLE;
            end
            S_MOD:
                if (mdone)
                begin
                    raddr = mrem;
                    state_next = S_CHK;
                end
            S_CHK:
                if (!rd_used)
                begin
                    kwe = 1'b1; lwe = 1'b1; kaddr = home_reg; laddr = home_reg;
                    finish = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    mstart = 1'b1;
                    mdiv = rd_key;
                    state_next = S_RMOD;
                end
            S_RMOD:
                if (mdone)
                begin
                    raddr = mrem;
                    state_next = (mrem == home_reg) ? S_TAIL : S_PRED;
                end
            S_PRED:
                if (pred_stop)
                begin
                    raddr = home_reg;
                    state_next = S_TAIL;
                end
                else
                    raddr = rd_link[AW-1:0];
            S_TAIL:
                if (tail_stop)
                begin
                    raddr = cur_inc;
                    state_next = S_FREE;
                end
                else
                    raddr = rd_link[AW-1:0];
            S_FREE:
                if (cnt_reg >= n)
                begin
                    finish = 1'b1;
                    state_next = S_IDLE;
                end
                else if (!rd_used)
                    state_next = S_W1;
                else
                    raddr = cur_inc;
            S_W1:
            begin
                kwe = 1'b1; lwe = 1'b1; kaddr = free_reg; laddr = free_reg;
                kdata = disp_reg ? res_key_reg : key_reg;
                state_next = S_W2;
            end
            S_W2:
            begin
                lwe = 1'b1; laddr = tail_reg; ldata = {1'b0, free_reg};
                if (disp_reg)
                    state_next = S_W3;
                else
                begin
                    finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_W3:
            begin
                // predecessor takes the resident's link as it stands now
                lwe = pred_ok_reg; laddr = pred_reg;
                ldata = (tail_reg == home_reg) ? {1'b0, free_reg} : ilink_reg;
                state_next = S_W4;
            end
            S_W4:
            begin
                kwe = 1'b1; lwe = 1'b1; kaddr = home_reg; laddr = home_reg;
                kdata = key_reg;
                finish = 1'b1;
                state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    // sequencer registers, one table entry visited per cycle in the walks
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            size_reg <= 7'd64;
            cur_reg <= '0;
            home_reg <= '0;
            tail_reg <= '0;
            pred_reg <= '0;
            free_reg <= '0;
            pred_ok_reg <= 1'b0;
            disp_reg <= 1'b0;
            key_reg <= '0;
            res_key_reg <= '0;
            ilink_reg <= '0;
            used_cnt_reg <= '0;
            res_reg <= RES_FULL;
            outv_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (finish)
                outv_reg <= 1'b1;
            else if (outv_reg && m_axis_tready)
                outv_reg <= 1'b0;
            unique case (state_reg)
                S_CLEAR:
                    cur_reg <= cur_reg + AW'(1);
                S_IDLE:
                    if (cfg_valid && cfg_ready)
                    begin
                        size_reg <= cfg_data;
                        cur_reg <= '0;
                        used_cnt_reg <= '0;
                    end
                    else if (s_axis_tvalid && s_axis_tready)
                    begin
                        key_reg <= s_axis_tdata[KEY_W-1:0];
                        res_reg <= RES_FULL;
                    end
                S_RD:
                begin
                    res_reg.status <= ST_READ;
                    res_reg.read_key <= rd_key;
                    res_reg.read_used <= rd_used;
                    res_reg.read_next <= rd_link;
                end
                S_MOD:
                    if (mdone)
                        home_reg <= mrem;
                S_CHK:
                    if (!rd_used)
                    begin
                        used_cnt_reg <= used_cnt_reg + CW'(1);
                        res_reg.status <= ST_HOME;
                        res_reg.placed_slot <= home_reg;
                    end
                    else
                    begin
                        res_key_reg <= rd_key;
                        ilink_reg <= rd_link;
                    end
                S_RMOD:
                    if (mdone)
                    begin
                        disp_reg <= (mrem != home_reg);
                        pred_ok_reg <= 1'b0;
                        cnt_reg <= '0;
                        cur_reg <= mrem;
                    end
                S_PRED:
                begin
                    if (is_pred)
                    begin
                        pred_ok_reg <= 1'b1;
                        pred_reg <= cur_reg;
                    end
                    if (pred_stop)
                    begin
                        cur_reg <= home_reg;
                        cnt_reg <= '0;
                    end
                    else
                    begin
                        cur_reg <= rd_link[AW-1:0];
                        cnt_reg <= cnt_reg + CW'(1);
                    end
                end
                S_TAIL:
                    if (tail_stop)
                    begin
                        tail_reg <= cur_reg;
                        cur_reg <= cur_inc;
                        cnt_reg <= CW'(1);
                    end
                    else
                    begin
                        cur_reg <= rd_link[AW-1:0];
                        cnt_reg <= cnt_reg + CW'(1);
                    end
                S_FREE:
                    if (cnt_reg < n)
                    begin
                        if (!rd_used)
                            free_reg <= cur_reg;
                        else
                        begin
                            cur_reg <= cur_inc;
                            cnt_reg <= cnt_reg + CW'(1);
                        end
                    end
                S_W2:
                    if (!disp_reg)
                    begin
                        used_cnt_reg <= used_cnt_reg + CW'(1);
                        res_reg.status <= ST_SYN;
                        res_reg.placed_slot <= free_reg;
                    end
                S_W4:
                begin
                    used_cnt_reg <= used_cnt_reg + CW'(1);
                    res_reg.status <= ST_MOVED;
                    res_reg.placed_slot <= home_reg;
                    res_reg.moved_slot <= free_reg;
                end
                default: ;
            endcase
        end
    end

endmodule

### rtl/core/hcri_modulo.sv
// iterative restoring remainder, one quotient bit per cycle
// depends on hcri_pkg
module hcri_modulo
    (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [hcri_pkg::KEY_W-1:0] dividend,
    input  logic [hcri_pkg::AW:0]      divisor,
    output logic                       done,
    output logic [hcri_pkg::AW-1:0]    remainder
    );
    import hcri_pkg::*;

    logic [KEY_W-1:0] shift_reg, shift_next;
    logic [AW-1:0]    rem_reg, rem_next;
    logic [5:0]       cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg;
    logic [AW:0]      trial;
    logic [AW:0]      diff;

    assign trial = {rem_reg, shift_reg[KEY_W-1]};
    assign diff  = trial - divisor;

    // one shift and subtract a cycle
    always_comb
    begin
        shift_next = shift_reg;
        rem_next   = rem_reg;
        cnt_next   = cnt_reg;
        busy_next  = busy_reg;
        if (start)
        begin
            shift_next = dividend;
            rem_next   = '0;
            cnt_next   = 6'(KEY_W);
            busy_next  = 1'b1;
        end
        else if (busy_reg)
        begin
            shift_next = {shift_reg[KEY_W-2:0], 1'b0};
            rem_next   = (trial >= divisor) ? diff[AW-1:0] : trial[AW-1:0];
            cnt_next   = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1)
                busy_next = 1'b0;
        end
    end

    assign remainder = rem_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        shift_reg <= shift_next;
        rem_reg   <= rem_next;
    end

    // done flags the cycle after the last step
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= busy_reg && (cnt_reg == 6'd1);
    end
    assign done = done_reg;

endmodule

### rtl/core/hcri_checker.sv
// port checker for the hash table top level
// depends on hash_chain_replace_insert_top ports
module hcri_checker
    (
    input logic clk,
    input logic rst_n,
    input logic s_axis_tvalid,
    input logic s_axis_tready,
    input logic m_axis_tvalid,
    input logic m_axis_tready,
    input logic [55:0] m_axis_tdata
    );
    // stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result word changed while stalled");
    // no accept while a result is pending
    a_one: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !s_axis_tready)
        else $error("accept with result pending");
    // status code in range
    a_stat: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[2:0] <= 3'd4)
        else $error("bad status");
endmodule

bind hash_chain_replace_insert_top hcri_checker u_chk
    (
    .clk(clk), .rst_n(rst_n), .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready), .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata)
    );
